// ===== hw/rtl/fes_pkg.sv =====
// Shared types and constants for the frame element stiffness pipeline.
// No dependencies; every other file imports this package.
package fes_pkg;

  localparam int RESULT_FRAC_BITS = 16;
  localparam int SQRT_STEPS = 63;
  localparam int DIV_STEPS = 63;
  localparam int NLANE = 7;
  localparam int NPROD = 6;

  localparam int LANE_CM = 0;
  localparam int LANE_SM = 1;
  localparam int LANE_A = 2;
  localparam int LANE_E = 3;
  localparam int LANE_F = 4;
  localparam int LANE_D = 5;
  localparam int LANE_B = 6;

  localparam logic [2:0] ROW_UX1 = 3'd0;
  localparam logic [2:0] ROW_UY1 = 3'd1;
  localparam logic [2:0] ROW_RZ1 = 3'd2;
  localparam logic [2:0] ROW_UX2 = 3'd3;
  localparam logic [2:0] ROW_UY2 = 3'd4;
  localparam logic [2:0] ROW_RZ2 = 3'd5;

  localparam logic [2:0] ELEM_GAP = 3'd5;
  localparam logic [63:0] SAT_MAX = 64'h7fff_ffff_ffff_ffff;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic [23:0] area;
    logic [19:0] modulus;
    logic [39:0] inertia;
  } in_word_t;

  typedef struct packed {
    logic [2:0] row_index;
    logic signed [63:0] entry_0;
    logic signed [63:0] entry_1;
    logic signed [63:0] entry_2;
    logic signed [63:0] entry_3;
    logic signed [63:0] entry_4;
    logic signed [63:0] entry_5;
    logic last_row;
    logic zero_length;
  } out_word_t;

  typedef struct packed {
    logic [32:0] ux;
    logic [32:0] uy;
    logic sc;
    logic ss;
    logic [43:0] ae;
    logic [59:0] ei;
    logic [65:0] s2;
    logic zl;
  } geo_t;

  typedef struct packed {
    logic sc;
    logic ss;
    logic zl;
  } tag_t;

  typedef struct packed {
    logic [63:0] k11;
    logic [63:0] k22;
    logic [63:0] k12;
    logic [63:0] ds;
    logic [63:0] dc;
    logic [63:0] e;
    logic [63:0] f;
    logic zl;
  } stiff_t;

endpackage

// ===== hw/rtl/frame_element_stiffness.sv =====
// Global 6x6 stiffness of one plane frame element, one row word per cycle. Pulse start
// with the element word while busy is low; busy then stays high while gap_r counts down, so
// elements are taken no faster than their six output rows leave. Rows appear on
// out_data with out_valid high for one cycle each, row 0 first, after the front, root,
// divider and rotation stages; the receiver takes every row as shown. The pipeline
// runs through the 63-step root and the divider lanes. Uses fes_pkg, fes_front, fes_sqrt,
// fes_quot, fes_rot.
module frame_element_stiffness import fes_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_word_t  in_data,
  output logic      busy,
  output logic      out_valid,
  output out_word_t out_data
);

  logic [2:0] gap_r;
  logic in_fire;
  logic geo_vld;
  geo_t geo;
  logic root_vld;
  geo_t root_geo;
  logic [62:0] root;
  logic quo_vld;
  tag_t quo_tag;
  logic [NLANE-1:0][63:0] quo;
  logic rot_vld;
  stiff_t stiff;
  stiff_t hold_r;
  logic act_r;
  logic [2:0] row_r;
  logic [63:0] ent [6];

  assign in_fire = start && !busy;
  assign busy = (gap_r != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= '0;
    end else if (in_fire) begin
      gap_r <= ELEM_GAP;
    end else if (gap_r != 3'd0) begin
      gap_r <= gap_r - 3'd1;
    end
  end

  fes_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_data (in_data),
    .geo_vld (geo_vld),
    .geo     (geo)
  );

  fes_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (geo_vld),
    .in_geo  (geo),
    .out_vld (root_vld),
    .out_geo (root_geo),
    .root    (root)
  );

  fes_quot u_quot (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (root_vld),
    .in_geo  (root_geo),
    .in_root (root),
    .out_vld (quo_vld),
    .out_tag (quo_tag),
    .out_quo (quo)
  );

  fes_rot u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (quo_vld),
    .in_tag    (quo_tag),
    .in_quo    (quo),
    .out_vld   (rot_vld),
    .out_stiff (stiff)
  );

  always_ff @(posedge clk) begin
    if (rot_vld) begin
      hold_r <= stiff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      row_r <= ROW_UX1;
    end else if (rot_vld) begin
      act_r <= 1'b1;
      row_r <= ROW_UX1;
    end else if (act_r) begin
      if (row_r == ROW_RZ2) begin
        act_r <= 1'b0;
        row_r <= ROW_UX1;
      end else begin
        row_r <= row_r + 3'd1;
      end
    end
  end

  always_comb begin
    unique case (row_r)
      ROW_UX1: begin
        ent[0] = hold_r.k11;  ent[1] = hold_r.k12;  ent[2] = -hold_r.ds;
        ent[3] = -hold_r.k11; ent[4] = -hold_r.k12; ent[5] = -hold_r.ds;
      end
      ROW_UY1: begin
        ent[0] = hold_r.k12;  ent[1] = hold_r.k22;  ent[2] = hold_r.dc;
        ent[3] = -hold_r.k12; ent[4] = -hold_r.k22; ent[5] = hold_r.dc;
      end
      ROW_RZ1: begin
        ent[0] = -hold_r.ds; ent[1] = hold_r.dc;  ent[2] = hold_r.e;
        ent[3] = hold_r.ds;  ent[4] = -hold_r.dc; ent[5] = hold_r.f;
      end
      ROW_UX2: begin
        ent[0] = -hold_r.k11; ent[1] = -hold_r.k12; ent[2] = hold_r.ds;
        ent[3] = hold_r.k11;  ent[4] = hold_r.k12;  ent[5] = hold_r.ds;
      end
      ROW_UY2: begin
        ent[0] = -hold_r.k12; ent[1] = -hold_r.k22; ent[2] = -hold_r.dc;
        ent[3] = hold_r.k12;  ent[4] = hold_r.k22;  ent[5] = -hold_r.dc;
      end
      ROW_RZ2: begin
        ent[0] = -hold_r.ds; ent[1] = hold_r.dc;  ent[2] = hold_r.f;
        ent[3] = hold_r.ds;  ent[4] = -hold_r.dc; ent[5] = hold_r.e;
      end
      default: begin
        for (int j = 0; j < 6; j++) begin
          ent[j] = '0;
        end
      end
    endcase
  end

  always_comb begin
    out_data.row_index = row_r;
    out_data.entry_0 = hold_r.zl ? '0 : ent[0];
    out_data.entry_1 = hold_r.zl ? '0 : ent[1];
    out_data.entry_2 = hold_r.zl ? '0 : ent[2];
    out_data.entry_3 = hold_r.zl ? '0 : ent[3];
    out_data.entry_4 = hold_r.zl ? '0 : ent[4];
    out_data.entry_5 = hold_r.zl ? '0 : ent[5];
    out_data.last_row = (row_r == ROW_RZ2);
    out_data.zero_length = hold_r.zl;
  end

  assign out_valid = act_r;

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> busy)
    else $error("busy low right after a start word");

  a_row_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last_row) |=>
      (out_valid && out_data.row_index == $past(out_data.row_index) + 3'd1))
    else $error("row sequence broken");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    rot_vld |-> (!act_r || row_r == ROW_RZ2))
    else $error("new element arrived over unfinished rows");

  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.zero_length) |-> (out_data.entry_0 == 64'sd0 &&
      out_data.entry_2 == 64'sd0 && out_data.entry_5 == 64'sd0))
    else $error("nonzero entry on a zero-length element");

endmodule

// ===== hw/rtl/fes_front.sv =====
// Input register, node deltas, axial/bending products and squared length.
// Depends on fes_pkg.
module fes_front import fes_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  in_word_t in_data,
  output logic     geo_vld,
  output geo_t     geo
);

  in_word_t in_r;
  logic [3:0] vld_r;
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  geo_t g1_r;
  geo_t g2_r;
  geo_t g3_r;
  logic [65:0] sqx_r;
  logic [65:0] sqy_r;
  logic [65:0] s2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_fire};
    end
  end

  assign dx = $signed({in_r.end_x[31], in_r.end_x}) - $signed({in_r.start_x[31], in_r.start_x});
  assign dy = $signed({in_r.end_y[31], in_r.end_y}) - $signed({in_r.start_y[31], in_r.start_y});
  assign s2 = sqx_r + sqy_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r <= in_data;
    end
    g1_r.ux <= dx[32] ? 33'(-dx) : 33'(dx);
    g1_r.uy <= dy[32] ? 33'(-dy) : 33'(dy);
    g1_r.sc <= dx[32];
    g1_r.ss <= dy[32];
    g1_r.ae <= 44'(in_r.area) * 44'(in_r.modulus);
    g1_r.ei <= 60'(in_r.modulus) * 60'(in_r.inertia);
    g1_r.s2 <= '0;
    g1_r.zl <= 1'b0;
    g2_r <= g1_r;
    sqx_r <= 66'(g1_r.ux) * 66'(g1_r.ux);
    sqy_r <= 66'(g1_r.uy) * 66'(g1_r.uy);
    g3_r.ux <= g2_r.ux;
    g3_r.uy <= g2_r.uy;
    g3_r.sc <= g2_r.sc;
    g3_r.ss <= g2_r.ss;
    g3_r.ae <= g2_r.ae;
    g3_r.ei <= g2_r.ei;
    g3_r.s2 <= s2;
    g3_r.zl <= (s2 == '0);
  end

  assign geo_vld = vld_r[3];
  assign geo = g3_r;

endmodule

// ===== hw/rtl/fes_sqrt.sv =====
// Pipelined bit-per-stage integer square root of the squared length scaled by 2^60.
// Depends on fes_pkg.
module fes_sqrt import fes_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  geo_t        in_geo,
  output logic        out_vld,
  output geo_t        out_geo,
  output logic [62:0] root
);

  logic [SQRT_STEPS:0] vld_r;
  logic [127:0] rem_r [SQRT_STEPS+1];
  logic [62:0] res_r [SQRT_STEPS+1];
  geo_t geo_r [SQRT_STEPS+1];
  logic [127:0] rem_nxt [SQRT_STEPS];
  logic [62:0] res_nxt [SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SQRT_STEPS-1:0], in_vld};
    end
  end

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
    localparam int J = SQRT_STEPS - 1 - g;
    logic [127:0] trial;
    logic take;
    assign trial = ({65'b0, res_r[g]} << (J + 1)) | (128'b1 << (2 * J));
    assign take = rem_r[g] >= trial;
    assign rem_nxt[g] = take ? rem_r[g] - trial : rem_r[g];
    assign res_nxt[g] = take ? (res_r[g] | (63'b1 << J)) : res_r[g];
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= {2'b0, in_geo.s2, 60'b0};
    res_r[0] <= '0;
    geo_r[0] <= in_geo;
    for (int g = 0; g < SQRT_STEPS; g++) begin
      rem_r[g+1] <= rem_nxt[g];
      res_r[g+1] <= res_nxt[g];
      geo_r[g+1] <= geo_r[g];
    end
  end

  assign out_vld = vld_r[SQRT_STEPS];
  assign out_geo = geo_r[SQRT_STEPS];
  assign root = res_r[SQRT_STEPS];

endmodule

// ===== hw/rtl/fes_quot.sv =====
// Seven-lane pipelined restoring divider: cosines and the AE/L, EI terms, rounded and
// saturated to 63 bits. Depends on fes_pkg.
module fes_quot import fes_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  geo_t                   in_geo,
  input  logic [62:0]            in_root,
  output logic                   out_vld,
  output tag_t                   out_tag,
  output logic [NLANE-1:0][63:0] out_quo
);

  localparam int NSTG = DIV_STEPS + 2;

  logic [DIV_STEPS+3:0] vld_r;
  logic [64:0] pp_r [4];
  logic [62:0] lq_r;
  geo_t geo_r;
  logic [127:0] denb;
  logic [127:0] ei6;
  logic [127:0] ei12;
  logic [127:0] num_nxt [NLANE];
  logic [127:0] dvs_nxt [NLANE];
  logic [127:0] num_r [NLANE];
  logic [127:0] dvs_r [NLANE];
  tag_t tag_q2_r;
  tag_t tag_r [NSTG];
  logic [127:0] rem_r [NLANE][NSTG];
  logic [127:0] den_r [NLANE][NSTG];
  logic [62:0] q_r [NLANE][NSTG];
  logic sat_r [NLANE][NSTG];
  logic [127:0] rem_nxt [NLANE][NSTG];
  logic [127:0] den_nxt [NLANE][NSTG];
  logic [62:0] q_nxt [NLANE][NSTG];
  logic sat_nxt [NLANE][NSTG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DIV_STEPS+2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    pp_r[0] <= 65'(in_geo.s2[32:0]) * 65'(in_root[31:0]);
    pp_r[1] <= 65'(in_geo.s2[32:0]) * 65'(in_root[62:32]);
    pp_r[2] <= 65'(in_geo.s2[65:33]) * 65'(in_root[31:0]);
    pp_r[3] <= 65'(in_geo.s2[65:33]) * 65'(in_root[62:32]);
    lq_r <= in_root;
    geo_r <= in_geo;
  end

  assign denb = 128'(pp_r[0]) + (128'(pp_r[1]) << 32) + (128'(pp_r[2]) << 33)
              + (128'(pp_r[3]) << 65);
  assign ei6 = (128'(geo_r.ei) << 2) + (128'(geo_r.ei) << 1);
  assign ei12 = (128'(geo_r.ei) << 3) + (128'(geo_r.ei) << 2);

  always_comb begin
    num_nxt[LANE_CM] = 128'(geo_r.ux) << 60;
    num_nxt[LANE_SM] = 128'(geo_r.uy) << 60;
    num_nxt[LANE_A] = 128'(geo_r.ae) << (RESULT_FRAC_BITS + 30);
    num_nxt[LANE_E] = 128'(geo_r.ei) << (RESULT_FRAC_BITS + 32);
    num_nxt[LANE_F] = 128'(geo_r.ei) << (RESULT_FRAC_BITS + 31);
    num_nxt[LANE_D] = ei6 << RESULT_FRAC_BITS;
    num_nxt[LANE_B] = ei12 << (RESULT_FRAC_BITS + 30);
    dvs_nxt[LANE_CM] = 128'(lq_r);
    dvs_nxt[LANE_SM] = 128'(lq_r);
    dvs_nxt[LANE_A] = 128'(lq_r);
    dvs_nxt[LANE_E] = 128'(lq_r);
    dvs_nxt[LANE_F] = 128'(lq_r);
    dvs_nxt[LANE_D] = 128'(geo_r.s2);
    dvs_nxt[LANE_B] = denb;
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < NLANE; l++) begin
      num_r[l] <= num_nxt[l];
      dvs_r[l] <= dvs_nxt[l];
    end
    tag_q2_r.sc <= geo_r.sc;
    tag_q2_r.ss <= geo_r.ss;
    tag_q2_r.zl <= geo_r.zl;
  end

  for (genvar l = 0; l < NLANE; l++) begin : g_lane
    assign rem_nxt[l][0] = num_r[l] + (dvs_r[l] >> 1);
    assign den_nxt[l][0] = dvs_r[l];
    assign q_nxt[l][0] = '0;
    assign sat_nxt[l][0] = 1'b0;
    for (genvar s = 1; s < NSTG; s++) begin : g_stage
      if (s == 1) begin : g_sat
        assign sat_nxt[l][s] = (rem_r[l][s-1] >> 63) >= den_r[l][s-1];
        assign rem_nxt[l][s] = rem_r[l][s-1];
        assign q_nxt[l][s] = q_r[l][s-1];
      end else begin : g_bit
        localparam int J = NSTG - 1 - s;
        logic ge;
        assign ge = (rem_r[l][s-1] >> J) >= den_r[l][s-1];
        assign sat_nxt[l][s] = sat_r[l][s-1];
        assign rem_nxt[l][s] = ge ? rem_r[l][s-1] - (den_r[l][s-1] << J) : rem_r[l][s-1];
        assign q_nxt[l][s] = ge ? (q_r[l][s-1] | (63'b1 << J)) : q_r[l][s-1];
      end
      assign den_nxt[l][s] = den_r[l][s-1];
    end
    assign out_quo[l] = sat_r[l][NSTG-1] ? SAT_MAX : {1'b0, q_r[l][NSTG-1]};
  end

  always_ff @(posedge clk) begin
    tag_r[0] <= tag_q2_r;
    for (int s = 1; s < NSTG; s++) begin
      tag_r[s] <= tag_r[s-1];
    end
    for (int l = 0; l < NLANE; l++) begin
      for (int s = 0; s < NSTG; s++) begin
        rem_r[l][s] <= rem_nxt[l][s];
        den_r[l][s] <= den_nxt[l][s];
        q_r[l][s] <= q_nxt[l][s];
        sat_r[l][s] <= sat_nxt[l][s];
      end
    end
  end

  assign out_vld = vld_r[DIV_STEPS+3];
  assign out_tag = tag_r[NSTG-1];

endmodule

// ===== hw/rtl/fes_rot.sv =====
// Rotation to global axes: cosine products, rounded scaling and signed combination.
// Depends on fes_pkg.
module fes_rot import fes_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  tag_t                   in_tag,
  input  logic [NLANE-1:0][63:0] in_quo,
  output logic                   out_vld,
  output stiff_t                 out_stiff
);

  logic [3:0] vld_r;
  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] d_r;
  logic [63:0] e1_r;
  logic [63:0] f1_r;
  logic [31:0] cm_r;
  logic [31:0] sm_r;
  logic [63:0] uv_r [3];
  tag_t tag1_r;
  logic [63:0] pp_nxt [NPROD][4];
  logic [63:0] pp_r [NPROD][4];
  logic [63:0] dpp_r [4];
  logic [63:0] e2_r;
  logic [63:0] f2_r;
  tag_t tag2_r;
  logic [127:0] psum [NPROD];
  logic [127:0] dssum;
  logic [127:0] dcsum;
  logic [63:0] p_r [NPROD];
  logic [63:0] ds_r;
  logic [63:0] dc_r;
  logic [63:0] e3_r;
  logic [63:0] f3_r;
  tag_t tag3_r;
  logic [63:0] k11;
  logic [63:0] k22;
  logic [63:0] k12;
  stiff_t st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    a_r <= in_quo[LANE_A];
    b_r <= in_quo[LANE_B];
    d_r <= in_quo[LANE_D];
    e1_r <= in_quo[LANE_E];
    f1_r <= in_quo[LANE_F];
    cm_r <= in_quo[LANE_CM][31:0];
    sm_r <= in_quo[LANE_SM][31:0];
    uv_r[0] <= 64'(in_quo[LANE_CM][31:0]) * 64'(in_quo[LANE_CM][31:0]);
    uv_r[1] <= 64'(in_quo[LANE_SM][31:0]) * 64'(in_quo[LANE_SM][31:0]);
    uv_r[2] <= 64'(in_quo[LANE_CM][31:0]) * 64'(in_quo[LANE_SM][31:0]);
    tag1_r <= in_tag;
  end

  for (genvar k = 0; k < NPROD; k++) begin : g_prod
    localparam bit USE_B = (k % 2) == 1;
    localparam int UVI = (k == 0 || k == 3) ? 0 : ((k == 1 || k == 2) ? 1 : 2);
    logic [63:0] xk;
    assign xk = USE_B ? b_r : a_r;
    assign pp_nxt[k][0] = 64'(xk[31:0]) * 64'(uv_r[UVI][31:0]);
    assign pp_nxt[k][1] = 64'(xk[31:0]) * 64'(uv_r[UVI][63:32]);
    assign pp_nxt[k][2] = 64'(xk[63:32]) * 64'(uv_r[UVI][31:0]);
    assign pp_nxt[k][3] = 64'(xk[63:32]) * 64'(uv_r[UVI][63:32]);
    assign psum[k] = 128'(pp_r[k][0]) + (128'(pp_r[k][1]) << 32) + (128'(pp_r[k][2]) << 32)
                   + (128'(pp_r[k][3]) << 64) + (128'b1 << 59);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NPROD; k++) begin
      for (int i = 0; i < 4; i++) begin
        pp_r[k][i] <= pp_nxt[k][i];
      end
    end
    dpp_r[0] <= 64'(d_r[31:0]) * 64'(sm_r);
    dpp_r[1] <= 64'(d_r[63:32]) * 64'(sm_r);
    dpp_r[2] <= 64'(d_r[31:0]) * 64'(cm_r);
    dpp_r[3] <= 64'(d_r[63:32]) * 64'(cm_r);
    e2_r <= e1_r;
    f2_r <= f1_r;
    tag2_r <= tag1_r;
  end

  assign dssum = 128'(dpp_r[0]) + (128'(dpp_r[1]) << 32) + (128'b1 << 29);
  assign dcsum = 128'(dpp_r[2]) + (128'(dpp_r[3]) << 32) + (128'b1 << 29);

  always_ff @(posedge clk) begin
    for (int k = 0; k < NPROD; k++) begin
      p_r[k] <= psum[k][123:60];
    end
    ds_r <= dssum[93:30];
    dc_r <= dcsum[93:30];
    e3_r <= e2_r;
    f3_r <= f2_r;
    tag3_r <= tag2_r;
  end

  assign k11 = p_r[0] + p_r[1];
  assign k22 = p_r[2] + p_r[3];
  assign k12 = p_r[4] - p_r[5];

  always_ff @(posedge clk) begin
    st_r.k11 <= k11[63] ? SAT_MAX : k11;
    st_r.k22 <= k22[63] ? SAT_MAX : k22;
    st_r.k12 <= (tag3_r.sc ^ tag3_r.ss) ? -k12 : k12;
    st_r.ds <= tag3_r.ss ? -ds_r : ds_r;
    st_r.dc <= tag3_r.sc ? -dc_r : dc_r;
    st_r.e <= e3_r;
    st_r.f <= f3_r;
    st_r.zl <= tag3_r.zl;
  end

  assign out_vld = vld_r[3];
  assign out_stiff = st_r;

endmodule

// ===== tb/sv/tb_frame_element_stiffness.sv =====
// Self-checking testbench for frame_element_stiffness: drives plane frame element words,
// predicts the six global stiffness rows in wide integer arithmetic and checks each row.
// Depends on fes_pkg and the frame_element_stiffness RTL.
`timescale 1ns / 100ps

module tb_frame_element_stiffness;
  import fes_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      start;
  in_word_t  in_data;
  logic      busy;
  logic      out_valid;
  out_word_t out_data;

  out_word_t expected_rows[$];
  int        mismatch_count;
  int        elements_sent;
  int        rows_checked;
  int        burst_left;

  frame_element_stiffness u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .in_data(in_data),
    .busy(busy),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_frame_element_stiffness NOT OK");
    $finish;
  end

  function automatic logic [127:0] round_quot(input logic [127:0] n, input logic [127:0] d);
    return (n + (d >> 1)) / d;
  endfunction

  function automatic logic [63:0] clamp63(input logic [127:0] q);
    return (q > 128'h7fff_ffff_ffff_ffff) ? SAT_MAX : q[63:0];
  endfunction

  function automatic logic [63:0] isqrt128(input logic [127:0] n);
    logic [127:0] res;
    logic [127:0] bitv;
    logic [127:0] t;
    res = '0;
    bitv = 128'd1 << 126;
    while (bitv != 0 && n < bitv) bitv = bitv >> 2;
    while (bitv != 0) begin
      t = res + bitv;
      if (n >= t) begin
        n = n - t;
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[63:0];
  endfunction

  function automatic logic [63:0] scale2(input logic [63:0] x, input logic [63:0] u,
                                         input logic [63:0] v);
    logic [63:0]  uv;
    logic [127:0] w;
    uv = u * v;
    w = {64'd0, x} * {64'd0, uv} + (128'd1 << 59);
    return w[123:60];
  endfunction

  function automatic logic [63:0] scale1(input logic [63:0] x, input logic [63:0] u);
    logic [127:0] w;
    w = {64'd0, x} * {64'd0, u} + (128'd1 << 29);
    return w[93:30];
  endfunction

  task automatic predict_rows(input in_word_t w);
    logic signed [33:0] dx, dy;
    logic [127:0] ux, uy, s2, lq, ae, ei, den_b;
    logic [63:0]  cm, sm, a, b, d, e, f, k11, k22, p1, p2, k12, ds, dc, nds, ndc;
    logic [63:0]  t[6][6];
    logic         zl;
    out_word_t    row;
    dx = 34'(w.end_x) - 34'(w.start_x);
    dy = 34'(w.end_y) - 34'(w.start_y);
    ux = dx[33] ? 128'(-dx) : 128'(dx);
    uy = dy[33] ? 128'(-dy) : 128'(dy);
    s2 = ux * ux + uy * uy;
    zl = (s2 == 0);
    for (int r = 0; r < 6; r++) for (int j = 0; j < 6; j++) t[r][j] = '0;
    if (!zl) begin
      lq = 128'(isqrt128(s2 << 60));
      cm = 64'(round_quot(ux << 60, lq));
      sm = 64'(round_quot(uy << 60, lq));
      ae = 128'(w.area) * 128'(w.modulus);
      ei = 128'(w.modulus) * 128'(w.inertia);
      den_b = s2 * lq;
      a = clamp63(round_quot(ae << (RESULT_FRAC_BITS + 30), lq));
      e = clamp63(round_quot((ei * 4) << (RESULT_FRAC_BITS + 30), lq));
      f = clamp63(round_quot((ei * 2) << (RESULT_FRAC_BITS + 30), lq));
      d = clamp63(round_quot((ei * 6) << RESULT_FRAC_BITS, s2));
      b = clamp63(round_quot((ei * 12) << (RESULT_FRAC_BITS + 30), den_b));
      k11 = scale2(a, cm, cm) + scale2(b, sm, sm);
      if (k11 > SAT_MAX) k11 = SAT_MAX;
      k22 = scale2(a, sm, sm) + scale2(b, cm, cm);
      if (k22 > SAT_MAX) k22 = SAT_MAX;
      p1 = scale2(a, cm, sm);
      p2 = scale2(b, cm, sm);
      k12 = p1 - p2;
      if (dx[33] != dy[33]) k12 = -k12;
      ds = scale1(d, sm);
      dc = scale1(d, cm);
      if (dy[33]) ds = -ds;
      if (dx[33]) dc = -dc;
      nds = -ds;
      ndc = -dc;
      t[0] = '{k11, k12, nds, -k11, -k12, nds};
      t[1] = '{k12, k22, dc, -k12, -k22, dc};
      t[2] = '{nds, dc, e, ds, ndc, f};
      t[3] = '{-k11, -k12, ds, k11, k12, ds};
      t[4] = '{-k12, -k22, ndc, k12, k22, ndc};
      t[5] = '{nds, dc, f, ds, ndc, e};
    end
    for (int r = 0; r < 6; r++) begin
      row.row_index = 3'(r);
      row.entry_0 = t[r][0];
      row.entry_1 = t[r][1];
      row.entry_2 = t[r][2];
      row.entry_3 = t[r][3];
      row.entry_4 = t[r][4];
      row.entry_5 = t[r][5];
      row.last_row = (3'(r) == ROW_RZ2);
      row.zero_length = zl;
      expected_rows = {expected_rows, row};
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH row word %0d %s: got %h want %h", rows_checked, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid) begin
      if (expected_rows.size() == 0) begin
        report_mismatch("unexpected word", 64'(out_data.row_index), 64'd0);
      end else begin
        want = expected_rows.pop_front();
        if (out_data.row_index !== want.row_index)
          report_mismatch("row_index", 64'(out_data.row_index), 64'(want.row_index));
        if (out_data.entry_0 !== want.entry_0)
          report_mismatch("entry_0", out_data.entry_0, want.entry_0);
        if (out_data.entry_1 !== want.entry_1)
          report_mismatch("entry_1", out_data.entry_1, want.entry_1);
        if (out_data.entry_2 !== want.entry_2)
          report_mismatch("entry_2", out_data.entry_2, want.entry_2);
        if (out_data.entry_3 !== want.entry_3)
          report_mismatch("entry_3", out_data.entry_3, want.entry_3);
        if (out_data.entry_4 !== want.entry_4)
          report_mismatch("entry_4", out_data.entry_4, want.entry_4);
        if (out_data.entry_5 !== want.entry_5)
          report_mismatch("entry_5", out_data.entry_5, want.entry_5);
        if (out_data.last_row !== want.last_row)
          report_mismatch("last_row", 64'(out_data.last_row), 64'(want.last_row));
        if (out_data.zero_length !== want.zero_length)
          report_mismatch("zero_length", 64'(out_data.zero_length), 64'(want.zero_length));
      end
      rows_checked++;
    end
  end

  task automatic send_element(input in_word_t w);
    start <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_rows(w);
    elements_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
  endtask

  function automatic in_word_t make_element(input logic [31:0] x0, input logic [31:0] y0,
                                            input logic [31:0] x1, input logic [31:0] y1,
                                            input logic [23:0] ar, input logic [19:0] md,
                                            input logic [39:0] in);
    in_word_t w;
    w.start_x = x0;
    w.start_y = y0;
    w.end_x = x1;
    w.end_y = y1;
    w.area = ar;
    w.modulus = md;
    w.inertia = in;
    return w;
  endfunction

  task automatic test_zero_length();
    send_element(make_element(0, 0, 0, 0, 24'd1000, 20'd200000, 40'd5000000));
    send_element(make_element(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                              '1, '1, '1));
  endtask

  task automatic test_extremes();
    send_element(make_element(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                              '1, '1, '1));
    send_element(make_element(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                              24'd1, 20'd1, 40'd1));
    send_element(make_element(32'h8000_0000, 0, 32'h7fff_ffff, 0, '1, '1, '1));
    send_element(make_element(0, 0, 1, 0, '1, '1, '1));
    send_element(make_element(0, 0, 0, 1, '1, '1, '1));
    send_element(make_element(5, 5, 6, 6, '1, '1, '1));
  endtask

  task automatic test_orientations();
    send_element(make_element(0, 0, 3000, 0, 24'd2000, 20'd210000, 40'd8000000));
    send_element(make_element(0, 0, -3000, 0, 24'd2000, 20'd210000, 40'd8000000));
    send_element(make_element(0, 0, 0, 4000, 24'd2000, 20'd210000, 40'd8000000));
    send_element(make_element(0, 0, 0, -4000, 24'd2000, 20'd210000, 40'd8000000));
    send_element(make_element(100, 200, 3100, 4200, 24'd2000, 20'd210000, 40'd8000000));
    send_element(make_element(100, 200, -2900, 4200, 24'd2000, 20'd210000, 40'd8000000));
    send_element(make_element(100, 200, -2900, -3800, 24'd2000, 20'd210000, 40'd8000000));
    send_element(make_element(100, 200, 3100, -3800, 24'd2000, 20'd210000, 40'd8000000));
  endtask

  task automatic test_section_sizes();
    send_element(make_element(0, 0, 2500, 1700, 24'd0, 20'd210000, 40'd8000000));
    send_element(make_element(0, 0, 2500, 1700, 24'd1500, 20'd0, 40'd8000000));
    send_element(make_element(0, 0, 2500, 1700, 24'd1500, 20'd210000, 40'd0));
    send_element(make_element(0, 0, 2500, 1700, 24'd0, 20'd0, 40'd0));
    send_element(make_element(-7, 3, 9, -12, '1, '1, '1));
  endtask

  function automatic in_word_t random_element();
    in_word_t w;
    logic [31:0] span;
    int mode;
    mode = $urandom_range(0, 9);
    span = 32'd1 << $urandom_range(1, 22);
    w.start_x = $urandom;
    w.start_y = $urandom;
    w.end_x = $urandom;
    w.end_y = $urandom;
    if (mode >= 3) begin
      w.start_x = $signed(w.start_x) >>> 8;
      w.start_y = $signed(w.start_y) >>> 8;
      w.end_x = w.start_x + $signed($urandom_range(0, 2 * span)) - $signed(span);
      w.end_y = w.start_y + $signed($urandom_range(0, 2 * span)) - $signed(span);
    end
    if (mode == 1) begin
      w.end_x = w.start_x;
      w.end_y = w.start_y;
    end
    if (mode == 2) begin
      if ($urandom_range(0, 1)) w.end_x = w.start_x;
      else w.end_y = w.start_y;
    end
    if ($urandom_range(0, 3) == 0) begin
      w.area = 24'($urandom);
      w.modulus = 20'($urandom);
      w.inertia = 40'({$urandom, $urandom});
    end else begin
      w.area = 24'($urandom_range(0, 50000));
      w.modulus = 20'($urandom_range(0, 250000));
      w.inertia = 40'($urandom_range(0, 32'h3fff_ffff));
    end
    return w;
  endfunction

  task automatic test_random(input int count);
    repeat (count) send_element(random_element());
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    mismatch_count = 0;
    elements_sent = 0;
    rows_checked = 0;
    burst_left = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_length();
    test_extremes();
    test_orientations();
    test_section_sizes();
    test_random(450);
    start <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (160) @(posedge clk);
    $display("Covered %0d elements (coincident, extreme, axis-aligned, saturating, random)",
             elements_sent);
    $display("Checked %0d row words, %0d mismatches", rows_checked, mismatch_count);
    if (mismatch_count == 0 && expected_rows.size() == 0) begin
      $display("tb_frame_element_stiffness OK");
    end else begin
      $display("tb_frame_element_stiffness NOT OK");
    end
    $finish;
  end

endmodule
